@@ rtl/hdaf_pkg.sv @@
// ----------------------------------------------------------------------------
// hdaf_pkg
// Shared types, codes and helpers of the hex/decimal ASCII formatter.
// ----------------------------------------------------------------------------
package hdaf_pkg;

  localparam int OP_W     = 2;
  localparam int VALUE_W  = 32;
  localparam int CHAR_W   = 8;
  localparam int DIGIT_W  = 4;

  // Decimal output never exceeds ten digits for a 32-bit value
  localparam int DEC_DIGITS = 10;
  localparam int DIG_W      = DEC_DIGITS * DIGIT_W;
  localparam int CNT_W      = $clog2(DEC_DIGITS + 1);

  typedef logic [OP_W-1:0]    op_t;
  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [DIGIT_W-1:0] digit_t;

  localparam op_t OP_LITERAL = 2'd0;
  localparam op_t OP_HEX     = 2'd1;
  localparam op_t OP_DECIMAL = 2'd2;

  localparam char_t CHAR_ZERO  = 8'h30;
  localparam char_t CHAR_A_LOW = 8'h61;
  localparam digit_t DIGIT_TEN = 4'd10;

  function automatic char_t digit_to_ascii(input digit_t d);
    char_t c;
    if (d < DIGIT_TEN) begin
      c = CHAR_ZERO + char_t'(d);
    end else begin
      c = CHAR_A_LOW + char_t'(d - DIGIT_TEN);
    end
    return c;
  endfunction

endpackage

@@ rtl/hdaf_if.sv @@
// ----------------------------------------------------------------------------
// hdaf_in_if / hdaf_out_if
// Valid/ready channels for format requests and for output characters.
// ----------------------------------------------------------------------------
interface hdaf_in_if;
  logic              valid;
  logic              ready;
  hdaf_pkg::op_t     operation;
  hdaf_pkg::value_t  value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface hdaf_out_if;
  logic             valid;
  logic             ready;
  hdaf_pkg::char_t  character;
  logic             last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

@@ rtl/hex_decimal_ascii_formatter.sv @@
// ----------------------------------------------------------------------------
// hex_decimal_ascii_formatter
// Turns one format request into a burst of ASCII characters, last one marked.
// ----------------------------------------------------------------------------
// One request is worked on at a time; in_chan.ready is high only while the
// block is idle. A literal goes out as one character, by way of the emit
// state. A hex request walks its (VALUE_BITS+3)/4 nibbles, one per cycle
// while the output is not stalled, dropping leading zeros. A decimal request
// first runs a bit-serial binary-to-BCD shift register (one value bit a
// cycle) and then walks ten BCD digits, one per cycle while the output is
// not stalled, also dropping leading zeros. The next request is taken while
// the final character still waits in the output register. Operation code 3
// is taken and dropped without output.
module hex_decimal_ascii_formatter #(
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  hdaf_in_if.sink     in_chan,
  hdaf_out_if.source  out_chan
);

  localparam int NIB    = (VALUE_BITS + 3) / 4;
  localparam int NIB_W  = NIB * hdaf_pkg::DIGIT_W;
  localparam int BCNT_W = $clog2(VALUE_BITS + 1);
  localparam int DW     = hdaf_pkg::DIG_W;
  localparam int CW     = hdaf_pkg::CNT_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DABBLE = 2'd1;
  localparam logic [1:0] ST_EMIT   = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [VALUE_BITS-1:0] bin_r, bin_nxt;
  logic [DW-1:0]         dig_r, dig_nxt;
  logic [DW-1:0]         dig_corr;
  logic [BCNT_W-1:0]     bit_cnt_r, bit_cnt_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  started_r, started_nxt;
  logic                  lit_r, lit_nxt;
  logic                  out_valid_r, out_valid_nxt;
  hdaf_pkg::char_t       out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;
  hdaf_pkg::digit_t      digit;
  logic                  skip;
  logic                  in_xfer;

  assign in_chan.ready      = (state_r == ST_IDLE);
  assign in_xfer            = in_chan.valid && in_chan.ready;
  assign out_chan.valid     = out_valid_r;
  assign out_chan.character = out_char_r;
  assign out_chan.last      = out_last_r;

  assign digit = dig_r[DW-1 -: hdaf_pkg::DIGIT_W];
  // Drop a leading zero, but never the final digit
  assign skip  = !lit_r && !started_r && (digit == '0) && (cnt_r > CW'(1));

  // Add-3 correction on every BCD digit ahead of the shift
  always_comb begin
    for (int i = 0; i < hdaf_pkg::DEC_DIGITS; i++) begin
      if (dig_r[i*hdaf_pkg::DIGIT_W +: hdaf_pkg::DIGIT_W] >= 4'd5) begin
        dig_corr[i*hdaf_pkg::DIGIT_W +: hdaf_pkg::DIGIT_W] =
          dig_r[i*hdaf_pkg::DIGIT_W +: hdaf_pkg::DIGIT_W] + 4'd3;
      end else begin
        dig_corr[i*hdaf_pkg::DIGIT_W +: hdaf_pkg::DIGIT_W] =
          dig_r[i*hdaf_pkg::DIGIT_W +: hdaf_pkg::DIGIT_W];
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    bin_nxt       = bin_r;
    dig_nxt       = dig_r;
    bit_cnt_nxt   = bit_cnt_r;
    cnt_nxt       = cnt_r;
    started_nxt   = started_r;
    lit_nxt       = lit_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          started_nxt = 1'b0;
          lit_nxt     = 1'b0;
          bin_nxt     = in_chan.value[VALUE_BITS-1:0];
          case (in_chan.operation)
            hdaf_pkg::OP_LITERAL: begin
              lit_nxt   = 1'b1;
              cnt_nxt   = CW'(1);
              state_nxt = ST_EMIT;
            end
            hdaf_pkg::OP_HEX: begin
              dig_nxt   = {NIB_W'(in_chan.value[VALUE_BITS-1:0]), {(DW-NIB_W){1'b0}}};
              cnt_nxt   = CW'(NIB);
              state_nxt = ST_EMIT;
            end
            hdaf_pkg::OP_DECIMAL: begin
              dig_nxt     = '0;
              bit_cnt_nxt = BCNT_W'(VALUE_BITS);
              state_nxt   = ST_DABBLE;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_DABBLE: begin
        dig_nxt     = {dig_corr[DW-2:0], bin_r[VALUE_BITS-1]};
        bin_nxt     = bin_r << 1;
        bit_cnt_nxt = bit_cnt_r - BCNT_W'(1);
        if (bit_cnt_r == BCNT_W'(1)) begin
          cnt_nxt   = CW'(hdaf_pkg::DEC_DIGITS);
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (skip) begin
          dig_nxt = {dig_r[DW-hdaf_pkg::DIGIT_W-1:0], {hdaf_pkg::DIGIT_W{1'b0}}};
          cnt_nxt = cnt_r - CW'(1);
        end else if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = lit_r ? bin_r[7:0] : hdaf_pkg::digit_to_ascii(digit);
          out_last_nxt  = (cnt_r == CW'(1));
          dig_nxt       = {dig_r[DW-hdaf_pkg::DIGIT_W-1:0], {hdaf_pkg::DIGIT_W{1'b0}}};
          cnt_nxt       = cnt_r - CW'(1);
          started_nxt   = 1'b1;
          if (cnt_r == CW'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bit_cnt_r   <= '0;
      cnt_r       <= '0;
      started_r   <= 1'b0;
      lit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      cnt_r       <= cnt_nxt;
      started_r   <= started_nxt;
      lit_r       <= lit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r      <= bin_nxt;
    dig_r      <= dig_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

`ifndef NO_ASSERTIONS
  a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (cnt_r != '0))
    else $error("emit state with no digits left");

  a_dabble_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DABBLE) |-> (bit_cnt_r != '0))
    else $error("conversion running with no bits left");

  a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (state_r == ST_EMIT))
    else $error("non-final character held with no burst in progress");
`endif

endmodule

@@ tb/tb_hex_decimal_ascii_formatter.sv @@
// ----------------------------------------------------------------------------
// tb_hex_decimal_ascii_formatter
// Drives literal, hex and decimal format requests into the formatter with
// random gaps and output stalls. Each request is expanded into the characters
// it must produce, and every output character is checked in order, with its
// last flag, against that expansion.
// ----------------------------------------------------------------------------
module tb_hex_decimal_ascii_formatter;

  localparam int VALUE_BITS    = 32;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_ITEMS  = 250;
  localparam int SETTLE_CYCLES = 60;
  localparam hdaf_pkg::op_t OP_UNUSED = 2'd3;

  typedef struct packed {
    hdaf_pkg::char_t character;
    logic            last;
  } out_char_t;

  class char_scoreboard;
    out_char_t   pending_chars[$];
    int unsigned errors;

    task report_mismatch(string what);
      errors++;
      $display("MISMATCH: %s", what);
    endtask

    // Expand one request into the characters it must print
    function void note_request(hdaf_pkg::op_t op, hdaf_pkg::value_t value);
      out_char_t        burst[$];
      hdaf_pkg::value_t rest;
      hdaf_pkg::value_t scale;
      hdaf_pkg::digit_t digit;
      bit               started;
      started = 1'b0;
      case (op)
        hdaf_pkg::OP_LITERAL: begin
          burst.push_back('{value[7:0], 1'b0});
        end
        hdaf_pkg::OP_HEX: begin
          for (int nib = (VALUE_BITS + 3) / 4 - 1; nib >= 0; nib--) begin
            digit = value[nib*4 +: 4];
            if (digit != 0 || nib == 0) started = 1'b1;
            if (started) begin
              burst.push_back('{(digit < hdaf_pkg::DIGIT_TEN)
                                 ? hdaf_pkg::CHAR_ZERO + hdaf_pkg::char_t'(digit)
                                 : hdaf_pkg::CHAR_A_LOW + hdaf_pkg::char_t'(digit) - 8'd10,
                                1'b0});
            end
          end
        end
        hdaf_pkg::OP_DECIMAL: begin
          rest  = value;
          scale = 32'd1000000000;
          while (scale > 1 && rest < scale) scale = scale / 10;
          while (scale != 0) begin
            digit = '0;
            while (rest >= scale) begin
              rest  = rest - scale;
              digit = digit + 1'b1;
            end
            burst.push_back('{hdaf_pkg::CHAR_ZERO + hdaf_pkg::char_t'(digit), 1'b0});
            scale = scale / 10;
          end
        end
        default: begin
        end
      endcase
      if (burst.size() != 0) begin
        burst[burst.size()-1].last = 1'b1;
        pending_chars = {pending_chars, burst};
      end
    endfunction

    task check_char(hdaf_pkg::char_t character, logic last);
      out_char_t want;
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%02h last=%b", character, last));
      end else begin
        want = pending_chars.pop_front();
        if (character !== want.character)
          report_mismatch($sformatf("character 0x%02h, wanted 0x%02h",
                                    character, want.character));
        if (last !== want.last)
          report_mismatch($sformatf("last=%b on 0x%02h, wanted %b",
                                    last, character, want.last));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   cycles;
  bit   calm;
  int   hold_off_cycles;

  hdaf_in_if  in_chan();
  hdaf_out_if out_chan();

  char_scoreboard board = new();

  hex_decimal_ascii_formatter #(.VALUE_BITS(VALUE_BITS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      board.check_char(out_chan.character, out_chan.last);
  end

  // Output side: random stalls, plus one long hold-off on request
  initial begin : char_sink
    int   stall_left;
    int   roll;
    logic rdy;
    stall_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles != 0) begin
        stall_left      = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (stall_left > 0) begin
        rdy = 1'b0;
        stall_left--;
      end else if (calm) begin
        rdy = 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          rdy = 1'b1;
        end else if (roll < 96) begin
          rdy        = 1'b0;
          stall_left = $urandom_range(0, 2);
        end else begin
          rdy        = 1'b0;
          stall_left = $urandom_range(10, 40);
        end
      end
      out_chan.ready <= rdy;
    end
  end

  // Hold valid high across back-to-back transfers; only a gap or a drain wait lowers it
  task send_request(hdaf_pkg::op_t op, hdaf_pkg::value_t value);
    in_chan.valid     <= 1'b1;
    in_chan.operation <= op;
    in_chan.value     <= value;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    board.note_request(op, value);
  endtask

  task sender_gap();
    int roll;
    int gap;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) gap = 0;
    else if (roll < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 50);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task wait_drained();
    in_chan.valid <= 1'b0;
    while (board.pending_chars.size() != 0) @(posedge clk);
  endtask

  function automatic hdaf_pkg::value_t pick_value();
    hdaf_pkg::value_t scale;
    int               k;
    k     = $urandom_range(0, 9);
    scale = 1;
    repeat (k) scale = scale * 10;
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return $urandom >> $urandom_range(0, 31);
      2:       return $urandom_range(0, 20);
      3:       return scale + $urandom_range(0, 2) - 1;
      4:       return 32'hF << (4 * $urandom_range(0, 7));
      default: return $urandom;
    endcase
  endfunction

  initial begin : request_source
    int               formatted;
    int               roll;
    hdaf_pkg::op_t    op;
    hdaf_pkg::value_t v;
    cycles            = 0;
    calm              = 1'b0;
    hold_off_cycles   = 0;
    rst_n             <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.operation <= hdaf_pkg::OP_LITERAL;
    in_chan.value     <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, zero, upper literal bits, unused code
    send_request(hdaf_pkg::OP_LITERAL, 32'h0000_0000);  sender_gap();
    send_request(hdaf_pkg::OP_LITERAL, 32'h0000_00FF);  sender_gap();
    send_request(hdaf_pkg::OP_LITERAL, 32'hABCD_EF41);  sender_gap();
    send_request(hdaf_pkg::OP_LITERAL, 32'hFFFF_FF25);  sender_gap();
    send_request(hdaf_pkg::OP_HEX,     32'h0000_0000);  sender_gap();
    send_request(hdaf_pkg::OP_HEX,     32'hFFFF_FFFF);  sender_gap();
    send_request(hdaf_pkg::OP_HEX,     32'h8000_0000);  sender_gap();
    send_request(hdaf_pkg::OP_HEX,     32'h0000_0001);  sender_gap();
    send_request(hdaf_pkg::OP_HEX,     32'h9ABC_DEF0);  sender_gap();
    send_request(hdaf_pkg::OP_HEX,     32'h0123_4567);  sender_gap();
    send_request(OP_UNUSED,            32'h0000_0000);  sender_gap();
    send_request(hdaf_pkg::OP_DECIMAL, 32'h0000_0000);  sender_gap();
    send_request(hdaf_pkg::OP_DECIMAL, 32'hFFFF_FFFF);  sender_gap();
    send_request(hdaf_pkg::OP_DECIMAL, 32'd1000000000); sender_gap();
    send_request(hdaf_pkg::OP_DECIMAL, 32'd999999999);  sender_gap();
    send_request(hdaf_pkg::OP_DECIMAL, 32'd9);          sender_gap();
    send_request(hdaf_pkg::OP_DECIMAL, 32'd10);         sender_gap();
    send_request(hdaf_pkg::OP_DECIMAL, 32'd1);          sender_gap();
    send_request(OP_UNUSED,            32'hFFFF_FFFF);  sender_gap();
    send_request(hdaf_pkg::OP_LITERAL, 32'h0000_0041);
    wait_drained();

    formatted = 0;
    while (formatted < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 30) op = hdaf_pkg::OP_LITERAL;
      else if (roll < 63) op = hdaf_pkg::OP_HEX;
      else if (roll < 95) op = hdaf_pkg::OP_DECIMAL;
      else op = OP_UNUSED;
      v = (op == hdaf_pkg::OP_LITERAL && roll[0]) ? $urandom : pick_value();
      send_request(op, v);
      if (op != OP_UNUSED) formatted++;
      // back-to-back stretch, then a long output hold-off, then a full pause
      if (formatted == 60) calm = 1'b1;
      if (formatted == 100) calm = 1'b0;
      if (formatted == 130 && op != OP_UNUSED) hold_off_cycles = 400;
      if (formatted == 190 && op != OP_UNUSED) wait_drained();
      sender_gap();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
